// ===== rtl/mhzp_pkg.sv =====
// shared types, constants and helper functions for the mhz text parser
package mhzp_pkg;

    // character and field widths
    localparam int CHAR_W  = 8;
    localparam int ACC_W   = 20;
    localparam int CNT_W   = 3;
    localparam int HZ_W    = 40;
    localparam int DIGIT_W = 4;

    // parse phase codes
    localparam logic [2:0] PH_LEAD  = 3'd0;
    localparam logic [2:0] PH_INT   = 3'd1;
    localparam logic [2:0] PH_DOT   = 3'd2;
    localparam logic [2:0] PH_FRAC  = 3'd3;
    localparam logic [2:0] PH_TRAIL = 3'd4;

    // character codes
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'd0;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'd46;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'd57;

    localparam logic [CNT_W-1:0] MAX_DIGITS = 3'd6;
    localparam logic [ACC_W-1:0] HZ_PER_MHZ = 20'd1000000;
    localparam logic [HZ_W-1:0]  HZ_MAX     = 40'd999999999999;

    // parser state handed to the result stage on the terminator
    typedef struct packed {
        logic             ok;
        logic [ACC_W-1:0] int_accum;
        logic [ACC_W-1:0] frac_micro;
    } t_snapshot;

    // whitespace: space, tab, lf, vt, ff, cr
    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // weight in millionths of the fraction digit at position cnt (0 = tenths)
    function automatic logic [ACC_W-1:0] frac_weight(input logic [CNT_W-1:0] cnt);
        logic [ACC_W-1:0] w;
        case (cnt)
            3'd0:    w = 20'd100000;
            3'd1:    w = 20'd10000;
            3'd2:    w = 20'd1000;
            3'd3:    w = 20'd100;
            3'd4:    w = 20'd10;
            3'd5:    w = 20'd1;
            default: w = 20'd0;
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/mhzp_parser.sv =====
// input word register and character-by-character parse state
module mhzp_parser (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [mhzp_pkg::CHAR_W-1:0] i_text_char,
    input  logic                       i_res_ready,
    output logic                       o_res_fire,
    output mhzp_pkg::t_snapshot        o_snap
);
    import mhzp_pkg::*;

    logic                r_in_valid;
    logic [CHAR_W-1:0]   r_in_char;
    logic [2:0]          r_phase,    n_phase;
    logic [ACC_W-1:0]    r_int,      n_int;
    logic [CNT_W-1:0]    r_int_cnt,  n_int_cnt;
    logic [ACC_W-1:0]    r_frac,     n_frac;
    logic [CNT_W-1:0]    r_frac_cnt, n_frac_cnt;
    logic                r_reject,   n_reject;

    logic                w_term;
    logic                w_take;
    logic                w_space;
    logic                w_digit;
    logic [DIGIT_W-1:0]  w_dval;

    // word in the input register moves on unless it is a terminator facing a full output
    assign w_term  = (r_in_char == CH_NUL);
    assign w_take  = r_in_valid && (!w_term || i_res_ready);
    assign o_ready = !r_in_valid || w_take;

    assign w_space = is_space(r_in_char);
    assign w_digit = is_digit(r_in_char);
    assign w_dval  = DIGIT_W'(r_in_char - CH_ZERO);

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_in_char <= i_text_char;
        end
    end

    // result snapshot taken on the terminator
    assign o_res_fire       = w_take && w_term;
    assign o_snap.ok        = !r_reject && (r_int_cnt != '0) &&
                              ((r_phase == PH_INT) || (r_phase == PH_FRAC) ||
                               (r_phase == PH_TRAIL));
    assign o_snap.int_accum  = r_int;
    assign o_snap.frac_micro = r_frac;

    // next parse state
    always_comb begin
        n_phase    = r_phase;
        n_int      = r_int;
        n_int_cnt  = r_int_cnt;
        n_frac     = r_frac;
        n_frac_cnt = r_frac_cnt;
        n_reject   = r_reject;
        if (w_take) begin
            if (w_term) begin
                n_phase    = PH_LEAD;
                n_int      = '0;
                n_int_cnt  = '0;
                n_frac     = '0;
                n_frac_cnt = '0;
                n_reject   = 1'b0;
            end else if (!r_reject) begin
                unique case (r_phase)
                    PH_LEAD: begin
                        if (w_digit) begin
                            n_int     = ACC_W'(w_dval);
                            n_int_cnt = CNT_W'(1);
                            n_phase   = PH_INT;
                        end else if (!w_space) begin
                            n_reject = 1'b1;
                        end
                    end
                    PH_INT: begin
                        if (w_digit) begin
                            if (r_int_cnt >= MAX_DIGITS) begin
                                n_reject = 1'b1;
                            end else begin
                                n_int     = ACC_W'((r_int << 3) + (r_int << 1) + ACC_W'(w_dval));
                                n_int_cnt = r_int_cnt + CNT_W'(1);
                            end
                        end else if (r_in_char == CH_DOT) begin
                            n_phase = PH_DOT;
                        end else if (w_space) begin
                            n_phase = PH_TRAIL;
                        end else begin
                            n_reject = 1'b1;
                        end
                    end
                    PH_DOT, PH_FRAC: begin
                        if (w_digit) begin
                            // digits past the sixth must be zero
                            if (r_frac_cnt < MAX_DIGITS) begin
                                n_frac     = r_frac + ACC_W'(ACC_W'(w_dval) *
                                                             frac_weight(r_frac_cnt));
                                n_frac_cnt = r_frac_cnt + CNT_W'(1);
                            end else if (r_in_char != CH_ZERO) begin
                                n_reject = 1'b1;
                            end
                            n_phase = PH_FRAC;
                        end else if ((r_phase == PH_FRAC) && w_space) begin
                            n_phase = PH_TRAIL;
                        end else begin
                            n_reject = 1'b1;
                        end
                    end
                    PH_TRAIL: begin
                        if (!w_space) begin
                            n_reject = 1'b1;
                        end
                    end
                    default: begin
                        n_reject = 1'b1;
                    end
                endcase
            end
        end
    end

    // parse state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_LEAD;
            r_int      <= '0;
            r_int_cnt  <= '0;
            r_frac     <= '0;
            r_frac_cnt <= '0;
            r_reject   <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_int      <= n_int;
            r_int_cnt  <= n_int_cnt;
            r_frac     <= n_frac;
            r_frac_cnt <= n_frac_cnt;
            r_reject   <= n_reject;
        end
    end

    // digit counts never pass six
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_int_cnt <= MAX_DIGITS) && (r_frac_cnt <= MAX_DIGITS))
        else $error("digit count out of range");

    // leading phase holds no digits
    a_lead_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_LEAD) |-> ((r_int_cnt == '0) && (r_frac_cnt == '0)))
        else $error("digits recorded in leading phase");

    // fraction phase implies at least one fraction digit and one integer digit
    a_frac_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_FRAC) |-> ((r_frac_cnt != '0) && (r_int_cnt != '0)))
        else $error("fraction phase without digits");

    // a terminator clears the state on the next edge
    a_term_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_fire |=> ((r_phase == PH_LEAD) && !r_reject && (r_int_cnt == '0)))
        else $error("state not cleared after terminator");

endmodule

// ===== rtl/mhzp_result.sv =====
// scaling of the parsed value to hertz and the result register
module mhzp_result (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_fire,
    input  mhzp_pkg::t_snapshot        i_snap,
    output logic                       o_res_ready,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [mhzp_pkg::HZ_W-1:0]  o_hz_value,
    output logic                       o_status
);
    import mhzp_pkg::*;

    logic              r_valid;
    logic [HZ_W-1:0]   r_hz;
    logic              r_status;
    logic [HZ_W-1:0]   w_prod;
    logic [HZ_W-1:0]   n_hz;

    // output register is free when empty or being drained
    assign o_res_ready = !r_valid || i_ready;

    // integer megahertz times one million plus the fraction in millionths
    assign w_prod = HZ_W'(i_snap.int_accum) * HZ_W'(HZ_PER_MHZ);
    assign n_hz   = i_snap.ok ? (w_prod + HZ_W'(i_snap.frac_micro)) : '0;

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_res_ready) begin
            r_valid <= i_fire;
        end
        if (o_res_ready && i_fire) begin
            r_hz     <= n_hz;
            r_status <= !i_snap.ok;
        end
    end

    assign o_valid    = r_valid;
    assign o_hz_value = r_hz;
    assign o_status   = r_status;

    // a rejected word carries zero hertz
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status) |-> (r_hz == '0))
        else $error("error result with nonzero value");

    // a good result stays within twelve decimal digits
    a_hz_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_status) |-> (r_hz <= HZ_MAX))
        else $error("result out of range");

endmodule

// ===== rtl/mhz_text_to_hz_parse.sv =====
// top level of the mhz text to hertz parser
//
// Input channel: one ASCII character per word on i_text_char, moved when
// i_valid and o_ready are both high. A NUL character ends the string.
// Output channel: one word per string, o_hz_value and o_status, moved when
// o_valid and i_ready are both high. o_status is 0 for a good string and 1
// for a rejected one, in which case o_hz_value is zero.
// Characters other than NUL produce no output word.
// The terminator, once taken, waits in the input register until the
// result register is free, and the result register then loads behind
// the parse logic.
// Throughput: one character per cycle unless a terminator is held; the per-cycle
// work is a small multiply-by-ten update of the parse state, and the
// terminator uses one constant multiply by one million before the result register.
// When the receiver stalls, ordinary characters keep flowing; only a
// terminator waits in the input register until the result register frees.
// Reset (synchronous, active low) empties both registers and returns the
// parser to its leading whitespace phase.
module mhz_text_to_hz_parse (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [mhzp_pkg::CHAR_W-1:0] i_text_char,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [mhzp_pkg::HZ_W-1:0]   o_hz_value,
    output logic                        o_status
);
    import mhzp_pkg::*;

    logic      w_res_ready;
    logic      w_res_fire;
    t_snapshot w_snap;

    mhzp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_text_char (i_text_char),
        .i_res_ready (w_res_ready),
        .o_res_fire  (w_res_fire),
        .o_snap      (w_snap)
    );

    mhzp_result u_result (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_res_fire),
        .i_snap      (w_snap),
        .o_res_ready (w_res_ready),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_hz_value  (o_hz_value),
        .o_status    (o_status)
    );

endmodule
